// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/dmm_pkg.sv =====
package dmm_pkg;

  localparam int WORD_BITS_DEF = 32;

  localparam int DIV_BITS   = 31;
  localparam int MULT_BITS  = 33;
  localparam int SHIFT_BITS = 6;
  localparam int LOG_BITS   = 5;
  localparam int PREC_BITS  = 6;

  localparam logic [PREC_BITS-1:0] PREC_RESET = PREC_BITS'(31);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_DIV,
    ST_REDUCE,
    ST_DONE
  } dmm_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic setup;
    logic div;
    logic reduce;
    logic emit;
  } dmm_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic scan_last;
    logic div_last;
    logic can_reduce;
    logic out_busy;
  } dmm_sts_t;

endpackage

// ===== sv/dmm_channels.sv =====
interface dmm_req_if import dmm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DIV_BITS-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink (input valid, input divisor, output ready);
endinterface

interface dmm_rsp_if import dmm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MULT_BITS-1:0]  multiplier;
  logic [SHIFT_BITS-1:0] post_shift;
  logic [LOG_BITS-1:0]   ceil_log;
  logic                  is_pow2;

  modport source (output valid, output multiplier, output post_shift,
                  output ceil_log, output is_pow2, input ready);
  modport sink (input valid, input multiplier, input post_shift,
                input ceil_log, input is_pow2, output ready);
endinterface

interface dmm_cfg_if import dmm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PREC_BITS-1:0] precision;

  modport source (output valid, output precision, input ready);
  modport sink (input valid, input precision, output ready);
endinterface

// ===== sv/dmm_ctrl.sv =====
module dmm_ctrl import dmm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  dmm_sts_t sts,
  output logic     req_ready,
  output dmm_cmd_t cmd
);

  dmm_state_t state;
  dmm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = sts.in_zero ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!sts.can_reduce) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
      end
      ST_REDUCE: begin
        cmd.reduce = sts.can_reduce;
      end
      ST_DONE: begin
        cmd.emit = !sts.out_busy;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/dmm_datapath.sv =====
module dmm_datapath import dmm_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dmm_cmd_t              cmd,
  output dmm_sts_t              sts,
  input  logic [DIV_BITS-1:0]   divisor,
  input  logic                  cfg_valid,
  input  logic [PREC_BITS-1:0]  cfg_precision,
  input  logic                  rsp_ready,
  output logic                  rsp_valid,
  output logic [MULT_BITS-1:0]  multiplier,
  output logic [SHIFT_BITS-1:0] post_shift,
  output logic [LOG_BITS-1:0]   ceil_log,
  output logic                  is_pow2
);

  // numerator bit index spans WORD_BITS + max ceil_log
  localparam int IDX_W = $clog2(WORD_BITS + (1 << LOG_BITS));
  // bounds stay below 3 * 2^WORD_BITS
  localparam int Q_W   = WORD_BITS + 2;

  logic [PREC_BITS-1:0] precision;
  logic [PREC_BITS-1:0] prec;
  logic [PREC_BITS-1:0] prec_next;

  logic [DIV_BITS-1:0]  dv;
  logic [DIV_BITS-1:0]  y;
  logic [LOG_BITS-1:0]  len;
  logic                 zero;
  logic                 pow2;
  logic [LOG_BITS-1:0]  l_reg;
  logic [LOG_BITS-1:0]  shift;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     top_pos;
  logic [IDX_W-1:0]     hp_pos;
  logic [DIV_BITS-1:0]  rem_lo;
  logic [DIV_BITS-1:0]  rem_hi;
  logic [Q_W-1:0]       q_lo;
  logic [Q_W-1:0]       q_hi;

  logic [LOG_BITS-1:0]  l_next;
  logic [IDX_W-1:0]     top_next;
  logic                 bit_lo;
  logic                 bit_hi;
  logic [DIV_BITS+1:0]  diff_lo;
  logic [DIV_BITS+1:0]  diff_hi;
  logic                 in_pow2;

  // precision register, clamped to 1..WORD_BITS when an item is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= PREC_RESET;
    end else if (cfg_valid) begin
      precision <= cfg_precision;
    end
  end

  always_comb begin
    if (precision == '0) begin
      prec_next = PREC_BITS'(1);
    end else if (precision > PREC_BITS'(WORD_BITS)) begin
      prec_next = PREC_BITS'(WORD_BITS);
    end else begin
      prec_next = precision;
    end
  end

  assign in_pow2  = ((divisor & (divisor - DIV_BITS'(1))) == '0);
  assign l_next   = pow2 ? (len - LOG_BITS'(1)) : len;
  assign top_next = IDX_W'(WORD_BITS) + IDX_W'(l_next);

  // one restoring step per cycle for each bound
  assign bit_lo  = (idx == top_pos);
  assign bit_hi  = (idx == top_pos) || (idx == hp_pos);
  assign diff_lo = {1'b0, rem_lo, bit_lo} - {2'b00, dv};
  assign diff_hi = {1'b0, rem_hi, bit_hi} - {2'b00, dv};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dv   <= divisor;
      y    <= divisor;
      len  <= '0;
      zero <= sts.in_zero;
      pow2 <= in_pow2;
      prec <= prec_next;
    end
    if (cmd.scan) begin
      y   <= y >> 1;
      len <= len + LOG_BITS'(1);
    end
    if (cmd.setup) begin
      l_reg   <= l_next;
      shift   <= l_next;
      top_pos <= top_next;
      hp_pos  <= top_next - IDX_W'(prec);
      idx     <= top_next;
      rem_lo  <= '0;
      rem_hi  <= '0;
      q_lo    <= '0;
      q_hi    <= '0;
    end
    if (cmd.div) begin
      idx <= idx - IDX_W'(1);
      if (!diff_lo[DIV_BITS+1]) begin
        rem_lo <= diff_lo[DIV_BITS-1:0];
      end else begin
        rem_lo <= {rem_lo[DIV_BITS-2:0], bit_lo};
      end
      if (!diff_hi[DIV_BITS+1]) begin
        rem_hi <= diff_hi[DIV_BITS-1:0];
      end else begin
        rem_hi <= {rem_hi[DIV_BITS-2:0], bit_hi};
      end
      q_lo <= {q_lo[Q_W-2:0], !diff_lo[DIV_BITS+1]};
      q_hi <= {q_hi[Q_W-2:0], !diff_hi[DIV_BITS+1]};
    end
    if (cmd.reduce) begin
      q_lo  <= q_lo >> 1;
      q_hi  <= q_hi >> 1;
      shift <= shift - LOG_BITS'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (zero) begin
        multiplier <= '0;
        post_shift <= '0;
        ceil_log   <= '0;
        is_pow2    <= 1'b0;
      end else begin
        multiplier <= MULT_BITS'(q_hi);
        post_shift <= SHIFT_BITS'(shift);
        ceil_log   <= l_reg;
        is_pow2    <= pow2;
      end
    end
  end

  always_comb begin
    sts.in_zero    = (divisor == '0);
    sts.scan_last  = (y[DIV_BITS-1:1] == '0);
    sts.div_last   = (idx == '0);
    sts.can_reduce = ((q_lo >> 1) < (q_hi >> 1)) && (shift != '0);
    sts.out_busy   = rsp_valid && !rsp_ready;
  end

endmodule

// ===== sv/division_magic_multiplier.sv =====
// Reciprocal multiplier chooser for division by a constant. Each transfer on
// req carries a divisor d (1..2^31-1); one transfer on rsp returns the magic
// multiplier m, the post shift s, l = ceil(log2 d) and a power-of-two flag,
// so that for dividends of `precision` bits, q = (x * m) >> (WORD_BITS + s).
// A zero divisor returns all-zero fields. The precision register is written
// over cfg (reset value 31; 0 acts as 1, values above WORD_BITS act as
// WORD_BITS) and must only be written while no item is in flight. Items are
// handled one at a time. A leading-one scan finds the bit length of d, a
// bit-serial restoring divider then forms both bounds side by side over the
// WORD_BITS + l + 1 numerator bits, and the reduction takes r <= l halving
// steps. A finished result sits in an output register, and the next divisor
// is taken as soon as it has been moved there.
`include "assert_macros.svh"

module division_magic_multiplier import dmm_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dmm_req_if.sink   req,
  dmm_rsp_if.source rsp,
  dmm_cfg_if.sink   cfg
);

  dmm_cmd_t cmd;
  dmm_sts_t sts;

  // config writes always land; the user must send them only while the block is idle, as the block does not enforce it
  assign cfg.ready = 1'b1;

  // sequencer: accept, scan, setup, divide, reduce, hand off
  dmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // bounds, dividers, shift counter and result register
  dmm_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .divisor       (req.divisor),
    .cfg_valid     (cfg.valid),
    .cfg_precision (cfg.precision),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .multiplier    (rsp.multiplier),
    .post_shift    (rsp.post_shift),
    .ceil_log      (rsp.ceil_log),
    .is_pow2       (rsp.is_pow2)
  );

  // only one item in flight: after a transfer in, req stays closed
  `ASSERT_NEXT(a_single_item, clk, rst, req.valid && req.ready, !req.ready)
  // the result register is loaded exactly when the controller hands off
  `ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, rsp.valid)
  // reduction never lowers the shift below zero nor raises it above l
  `ASSERT_IMPLIES(a_shift_le_log, clk, rst, rsp.valid, rsp.post_shift <= SHIFT_BITS'(rsp.ceil_log))

endmodule
